@@ design/sha256_pkg.sv @@
// shared types, constants and round functions for the sha-256 message hasher
package sha256_pkg;

    localparam int WordW  = 32;
    localparam int Rounds = 64;

    // one input item
    typedef struct packed {
        logic [31:0] message_word;
        logic [5:0]  valid_bits;
        logic        final_word;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_of_digest;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_UPDATE,
        S_OUT
    } t_state;

    // where the controller is within the message and its padding
    typedef enum logic [2:0] {
        PH_MSG,
        PH_ONE,
        PH_ZERO,
        PH_LEN_LO,
        PH_DIGEST
    } t_phase;

    // source of a word pushed into the schedule window
    typedef enum logic [2:0] {
        PS_WORD,
        PS_ONE,
        PS_ZERO,
        PS_LEN_HI,
        PS_LEN_LO
    } t_push_sel;

    typedef struct packed {
        logic      push;
        t_push_sel push_sel;
        logic      acc;
        logic      load_work;
        logic      round;
        logic      update;
        logic      clear;
        logic [2:0] out_idx;
    } t_cmd;

    typedef struct packed {
        logic wib_14;
        logic wib_15;
        logic round_last;
        logic full_final;
    } t_status;

    localparam logic [31:0] PadOne = 32'h8000_0000;

    function automatic logic [31:0] init_hash(input logic [2:0] i);
        case (i)
            3'd0:    init_hash = 32'h6a09e667;
            3'd1:    init_hash = 32'hbb67ae85;
            3'd2:    init_hash = 32'h3c6ef372;
            3'd3:    init_hash = 32'ha54ff53a;
            3'd4:    init_hash = 32'h510e527f;
            3'd5:    init_hash = 32'h9b05688c;
            3'd6:    init_hash = 32'h1f83d9ab;
            default: init_hash = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [31:0] round_const(input logic [5:0] t);
        case (t)
            6'd0:  round_const = 32'h428a2f98; 6'd1:  round_const = 32'h71374491;
            6'd2:  round_const = 32'hb5c0fbcf; 6'd3:  round_const = 32'he9b5dba5;
            6'd4:  round_const = 32'h3956c25b; 6'd5:  round_const = 32'h59f111f1;
            6'd6:  round_const = 32'h923f82a4; 6'd7:  round_const = 32'hab1c5ed5;
            6'd8:  round_const = 32'hd807aa98; 6'd9:  round_const = 32'h12835b01;
            6'd10: round_const = 32'h243185be; 6'd11: round_const = 32'h550c7dc3;
            6'd12: round_const = 32'h72be5d74; 6'd13: round_const = 32'h80deb1fe;
            6'd14: round_const = 32'h9bdc06a7; 6'd15: round_const = 32'hc19bf174;
            6'd16: round_const = 32'he49b69c1; 6'd17: round_const = 32'hefbe4786;
            6'd18: round_const = 32'h0fc19dc6; 6'd19: round_const = 32'h240ca1cc;
            6'd20: round_const = 32'h2de92c6f; 6'd21: round_const = 32'h4a7484aa;
            6'd22: round_const = 32'h5cb0a9dc; 6'd23: round_const = 32'h76f988da;
            6'd24: round_const = 32'h983e5152; 6'd25: round_const = 32'ha831c66d;
            6'd26: round_const = 32'hb00327c8; 6'd27: round_const = 32'hbf597fc7;
            6'd28: round_const = 32'hc6e00bf3; 6'd29: round_const = 32'hd5a79147;
            6'd30: round_const = 32'h06ca6351; 6'd31: round_const = 32'h14292967;
            6'd32: round_const = 32'h27b70a85; 6'd33: round_const = 32'h2e1b2138;
            6'd34: round_const = 32'h4d2c6dfc; 6'd35: round_const = 32'h53380d13;
            6'd36: round_const = 32'h650a7354; 6'd37: round_const = 32'h766a0abb;
            6'd38: round_const = 32'h81c2c92e; 6'd39: round_const = 32'h92722c85;
            6'd40: round_const = 32'ha2bfe8a1; 6'd41: round_const = 32'ha81a664b;
            6'd42: round_const = 32'hc24b8b70; 6'd43: round_const = 32'hc76c51a3;
            6'd44: round_const = 32'hd192e819; 6'd45: round_const = 32'hd6990624;
            6'd46: round_const = 32'hf40e3585; 6'd47: round_const = 32'h106aa070;
            6'd48: round_const = 32'h19a4c116; 6'd49: round_const = 32'h1e376c08;
            6'd50: round_const = 32'h2748774c; 6'd51: round_const = 32'h34b0bcb5;
            6'd52: round_const = 32'h391c0cb3; 6'd53: round_const = 32'h4ed8aa4a;
            6'd54: round_const = 32'h5b9cca4f; 6'd55: round_const = 32'h682e6ff3;
            6'd56: round_const = 32'h748f82ee; 6'd57: round_const = 32'h78a5636f;
            6'd58: round_const = 32'h84c87814; 6'd59: round_const = 32'h8cc70208;
            6'd60: round_const = 32'h90befffa; 6'd61: round_const = 32'ha4506ceb;
            6'd62: round_const = 32'hbef9a3f7; default: round_const = 32'hc67178f2;
        endcase
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (WordW - n));
    endfunction

endpackage

@@ design/sha256_ctrl.sv @@
// controller state machine: message intake, padding sequence, rounds and digest output
module sha256_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_final,
    input  logic                 i_stall,
    input  sha256_pkg::t_status  i_status,
    output logic                 o_stall,
    output logic                 o_valid,
    output sha256_pkg::t_cmd     o_cmd
);
    import sha256_pkg::*;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [2:0] r_out_idx, n_out_idx;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_valid && (r_state == S_IDLE);
    assign out_xfer = (r_state == S_OUT) && !i_stall;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_MSG;
            r_out_idx <= 3'd0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_out_idx <= n_out_idx;
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_out_idx = r_out_idx;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_final) begin
                        n_phase = i_status.full_final ? PH_ONE : PH_ZERO;
                    end
                    if (i_status.wib_15) begin
                        n_state = S_ROUND;
                    end else if (i_final) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                case (r_phase)
                    PH_ONE:    n_phase = PH_ZERO;
                    PH_ZERO:   n_phase = i_status.wib_14 ? PH_LEN_LO : PH_ZERO;
                    PH_LEN_LO: n_phase = PH_DIGEST;
                    default:   n_phase = r_phase;
                endcase
                if (i_status.wib_15) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (i_status.round_last) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                case (r_phase)
                    PH_MSG:    n_state = S_IDLE;
                    PH_DIGEST: n_state = S_OUT;
                    default:   n_state = S_PAD;
                endcase
                n_out_idx = 3'd0;
            end
            S_OUT: begin
                if (out_xfer) begin
                    n_out_idx = r_out_idx + 3'd1;
                    if (r_out_idx == 3'd7) begin
                        n_state = S_IDLE;
                        n_phase = PH_MSG;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd         = '0;
        o_cmd.push_sel = PS_WORD;
        o_cmd.out_idx = r_out_idx;
        o_stall       = (r_state != S_IDLE);
        o_valid       = (r_state == S_OUT);
        case (r_state)
            S_IDLE: begin
                o_cmd.push      = in_xfer;
                o_cmd.acc       = in_xfer;
                o_cmd.load_work = in_xfer && i_status.wib_15;
            end
            S_PAD: begin
                o_cmd.push      = 1'b1;
                o_cmd.load_work = i_status.wib_15;
                case (r_phase)
                    PH_ONE:    o_cmd.push_sel = PS_ONE;
                    PH_ZERO:   o_cmd.push_sel = i_status.wib_14 ? PS_LEN_HI : PS_ZERO;
                    PH_LEN_LO: o_cmd.push_sel = PS_LEN_LO;
                    default:   o_cmd.push_sel = PS_ZERO;
                endcase
            end
            S_ROUND:  o_cmd.round  = 1'b1;
            S_UPDATE: o_cmd.update = 1'b1;
            S_OUT:    o_cmd.clear  = out_xfer && (r_out_idx == 3'd7);
            default:  o_cmd.round  = 1'b0;
        endcase
    end

endmodule

@@ design/sha256_dp.sv @@
// datapath: bit counter, schedule window, working variables, round unit and chain value
module sha256_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sha256_pkg::t_in_item  i_item,
    input  sha256_pkg::t_cmd      i_cmd,
    output sha256_pkg::t_status   o_status,
    output sha256_pkg::t_out_item o_item
);
    import sha256_pkg::*;

    logic [31:0] r_chain [8];
    logic [31:0] r_work  [8];
    logic [31:0] r_win   [16];
    logic [3:0]  r_wib;
    logic [63:0] r_count;
    logic [5:0]  r_round;

    logic [5:0]  nbits;
    logic [31:0] keep;
    logic [31:0] push_word;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    // saturate the valid bit count of a final word
    assign nbits = (i_item.valid_bits > 6'd32) ? 6'd32 : i_item.valid_bits;
    assign keep  = ~(32'hffff_ffff >> nbits[4:0]);

    // word that goes into the window
    always_comb begin
        case (i_cmd.push_sel)
            PS_WORD: begin
                if (!i_item.final_word || nbits[5]) begin
                    push_word = i_item.message_word;
                end else begin
                    push_word = (i_item.message_word & keep) | (PadOne >> nbits[4:0]);
                end
            end
            PS_ONE:    push_word = PadOne;
            PS_LEN_HI: push_word = r_count[63:32];
            PS_LEN_LO: push_word = r_count[31:0];
            default:   push_word = 32'd0;
        endcase
    end

    // message schedule expansion and round function
    assign w_new = (rotr(r_win[14], 17) ^ rotr(r_win[14], 19) ^ (r_win[14] >> 10))
                 + r_win[9]
                 + (rotr(r_win[1], 7) ^ rotr(r_win[1], 18) ^ (r_win[1] >> 3))
                 + r_win[0];
    assign t1 = r_work[7] + (rotr(r_work[4], 6) ^ rotr(r_work[4], 11) ^ rotr(r_work[4], 25))
              + ((r_work[4] & r_work[5]) ^ (~r_work[4] & r_work[6]))
              + round_const(r_round) + r_win[0];
    assign t2 = (rotr(r_work[0], 2) ^ rotr(r_work[0], 13) ^ rotr(r_work[0], 22))
              + ((r_work[0] & r_work[1]) ^ (r_work[0] & r_work[2]) ^ (r_work[1] & r_work[2]));

    // control counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_wib   <= 4'd0;
            r_count <= 64'd0;
            r_round <= 6'd0;
        end else begin
            if (i_cmd.push) begin
                r_wib <= r_wib + 4'd1;
            end
            if (i_cmd.acc) begin
                r_count <= r_count + (i_item.final_word ? {58'd0, nbits} : 64'd32);
            end
            if (i_cmd.load_work) begin
                r_round <= 6'd0;
            end else if (i_cmd.round) begin
                r_round <= r_round + 6'd1;
            end
        end
    end

    // schedule window as a shift line, oldest word at index 0
    always_ff @(posedge i_clk) begin
        if (i_cmd.push || i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= i_cmd.push ? push_word : w_new;
        end
    end

    // working variables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_work[i] <= 32'd0;
            end
        end else if (i_cmd.load_work) begin
            for (int i = 0; i < 8; i++) begin
                r_work[i] <= r_chain[i];
            end
        end else if (i_cmd.round) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= t1 + t2;
        end
    end

    // chain value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= init_hash(3'(i));
            end
        end else if (i_cmd.update) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_work[i];
            end
        end
    end

    assign o_status.wib_14     = (r_wib == 4'd14);
    assign o_status.wib_15     = (r_wib == 4'd15);
    assign o_status.round_last = (r_round == 6'(Rounds - 1));
    assign o_status.full_final = nbits[5];

    assign o_item.digest_word    = r_chain[i_cmd.out_idx];
    assign o_item.word_index     = i_cmd.out_idx;
    assign o_item.last_of_digest = (i_cmd.out_idx == 3'd7);

endmodule

@@ design/sha256_message_hasher.sv @@
// top level of the sha-256 message hasher
// Takes a message as big-endian 32-bit words and returns its SHA-256 digest as eight
// words, index 0 first. The final word is marked and gives how many leading bits are
// valid (values above 32 count as 32), so lengths are exact to the bit. A word that
// does not complete a 16-word block is taken without a stall; a word that completes
// one stalls the input for the 64 rounds (one per cycle in the round unit) and the
// chain update. After the final word the block pushes one padding word per cycle,
// compressing each full block the same way, then shows the digest words one transfer
// per cycle while the receiver does not stall; input is stalled until the eighth word
// is taken, after which the block is ready for a new message.
module sha256_message_hasher (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  sha256_pkg::t_in_item  i_in_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output sha256_pkg::t_out_item o_out_data
);
    import sha256_pkg::*;

    t_cmd    cmd;
    t_status status;

    sha256_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_final  (i_in_data.final_word),
        .i_stall  (i_stall),
        .i_status (status),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .o_cmd    (cmd)
    );

    sha256_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_in_data),
        .i_cmd    (cmd),
        .o_status (status),
        .o_item   (o_out_data)
    );

endmodule

@@ verif/tb.sv @@
// testbench for the sha-256 message hasher: random and directed messages checked against a predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sha256_pkg::*;

    logic      i_clk;
    logic      i_rst_n;
    logic      in_valid;
    logic      dut_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;

    sha256_message_hasher i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (in_valid),
        .o_stall   (dut_stall),
        .i_in_data (in_data),
        .o_valid   (out_valid),
        .i_stall   (out_stall),
        .o_out_data(out_data)
    );

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam int LONG_HOLD = 400;

    // predictor state
    logic [31:0] hash_h [8];
    logic [31:0] blk_w [16];
    int          blk_fill;
    logic [63:0] bit_len;

    t_in_item  pending_words [$];
    t_out_item digest_queue [$];
    int        errors = 0;
    int        words_sent = 0;
    int        digests_done = 0;
    int        idle_cycles = 0;
    bit        hold_req;
    bit        pause_req;

    function automatic logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    // one 64-round compression over the gathered block
    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                w[t] = blk_w[t];
            end else begin
                s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = s1 + w[t-7] + s0 + w[t-16];
            end
        end
        {a, b, c, d, e, f, g, h} = {hash_h[0], hash_h[1], hash_h[2], hash_h[3],
                                    hash_h[4], hash_h[5], hash_h[6], hash_h[7]};
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
               + K_TAB[t] + w[t];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d;
        hash_h[4] += e; hash_h[5] += f; hash_h[6] += g; hash_h[7] += h;
    endtask

    task automatic absorb_word(logic [31:0] wd);
        blk_w[blk_fill] = wd;
        blk_fill = (blk_fill + 1) % 16;
        if (blk_fill == 0) compress_block();
    endtask

    task automatic hasher_restart();
        for (int i = 0; i < 8; i++) hash_h[i] = IV_TAB[i];
        blk_fill = 0;
        bit_len  = '0;
    endtask

    // predict the effect of one accepted transfer
    task automatic predict_word(t_in_item it);
        int          nb;
        logic [31:0] keep;
        t_out_item   r;
        if (!it.final_word) begin
            bit_len += 32;
            absorb_word(it.message_word);
            return;
        end
        nb = (it.valid_bits > 32) ? 32 : int'(it.valid_bits);
        bit_len += nb;
        if (nb == 32) begin
            absorb_word(it.message_word);
            absorb_word(PadOne);
        end else begin
            keep = (nb == 0) ? 32'h0 : (32'hffff_ffff << (32 - nb));
            absorb_word((it.message_word & keep) | (PadOne >> nb));
        end
        while (blk_fill != 14) absorb_word(32'h0);
        absorb_word(bit_len[63:32]);
        absorb_word(bit_len[31:0]);
        for (int i = 0; i < 8; i++) begin
            r.digest_word    = hash_h[i];
            r.word_index     = 3'(i);
            r.last_of_digest = (i == 7);
            digest_queue.push_back(r);
        end
        hasher_restart();
    endtask

    function automatic t_in_item mk_word(logic [31:0] wd, int nb, bit fin);
        t_in_item it;
        it.message_word = wd;
        it.valid_bits   = 6'(nb);
        it.final_word   = fin;
        return it;
    endfunction

    // queue one message of the given number of body words
    task automatic queue_message(int body, int nb);
        for (int i = 0; i < body; i++)
            pending_words.push_back(mk_word($urandom, $urandom_range(0, 63), 1'b0));
        pending_words.push_back(mk_word($urandom, nb, 1'b1));
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || digest_queue.size() != 0)
            @(posedge i_clk);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // sender side
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap <= 0;
        end else if (in_valid && dut_stall) begin
            // hold the offered transfer
        end else if (in_valid) begin
            predict_word(in_data);
            words_sent <= words_sent + 1;
            send_gap   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if ((send_gap == 0 || ($urandom_range(0, 1) == 0)) && !pause_req
                    && pending_words.size() != 0 && $urandom_range(0, 2) == 0) begin
                in_data  <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end else if (send_gap != 0) begin
            send_gap <= send_gap - 1;
        end else if (!pause_req && pending_words.size() != 0) begin
            in_data  <= pending_words.pop_front();
            in_valid <= 1'b1;
        end
    end

    // receiver side: random stalls plus one long hold
    int recv_gap;
    int hold_cnt;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
            recv_gap  <= 0;
            hold_cnt  <= 0;
        end else if (hold_req && hold_cnt < LONG_HOLD) begin
            out_stall <= 1'b1;
            hold_cnt  <= hold_cnt + 1;
        end else if (out_valid && !out_stall) begin
            recv_gap  <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            out_stall <= 1'b1;
        end else if (recv_gap != 0) begin
            recv_gap  <= recv_gap - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && out_valid && !out_stall) begin
            if (digest_queue.size() == 0) begin
                $error("unexpected digest transfer: word %h", out_data.digest_word);
                errors++;
            end else begin
                exp_item = digest_queue.pop_front();
                if (out_data.digest_word !== exp_item.digest_word) begin
                    $error("digest_word exp %h got %h", exp_item.digest_word,
                           out_data.digest_word);
                    errors++;
                end
                if (out_data.word_index !== exp_item.word_index) begin
                    $error("word_index exp %0d got %0d", exp_item.word_index,
                           out_data.word_index);
                    errors++;
                end
                if (out_data.last_of_digest !== exp_item.last_of_digest) begin
                    $error("last_of_digest exp %0d got %0d", exp_item.last_of_digest,
                           out_data.last_of_digest);
                    errors++;
                end
                if (exp_item.last_of_digest) digests_done++;
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((in_valid && !dut_stall) || (out_valid && !out_stall)
                || (hold_req && hold_cnt < LONG_HOLD))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("timeout with %0d digest words outstanding", digest_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int lens [8];
        hold_req = 0; pause_req = 0;
        hasher_restart();
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty message, valid-bit extremes, block boundaries
        pending_words.push_back(mk_word(32'hffff_ffff, 0, 1'b1));
        pending_words.push_back(mk_word(32'h6162_6380, 24, 1'b1));
        pending_words.push_back(mk_word(32'hffff_ffff, 32, 1'b1));
        pending_words.push_back(mk_word(32'hffff_ffff, 63, 1'b1));
        pending_words.push_back(mk_word(32'h0000_0000, 33, 1'b1));
        pending_words.push_back(mk_word(32'hffff_ffff, 1, 1'b1));
        pending_words.push_back(mk_word(32'hffff_ffff, 31, 1'b1));
        queue_message(13, 31);
        wait_drained();

        // pause until idle, then long receiver hold while sender keeps offering
        pause_req = 1;
        repeat (80) @(posedge i_clk);
        pause_req = 0;
        hold_req = 1;
        queue_message(2, 32);
        queue_message(20, 5);
        wait_drained();
        hold_req = 0;

        // random messages, mostly short
        while (words_sent < 125) begin
            lens = '{0, 1, 3, 13, 14, 15, 16, 30};
            queue_message($urandom_range(0, 3) == 0 ? lens[$urandom_range(0, 7)]
                                                    : $urandom_range(0, 6),
                          $urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                                                    : $urandom_range(0, 32));
            wait_drained();
        end
        repeat (100) @(posedge i_clk);

        $display("sent %0d message words, checked %0d digests", words_sent, digests_done);
        if (errors == 0 && digest_queue.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ sim.f @@
design/sha256_pkg.sv
design/sha256_ctrl.sv
design/sha256_dp.sv
design/sha256_message_hasher.sv
verif/tb.sv
